// ===== sv/leb_pkg.sv =====
// leb_pkg: shared types and constants of the line edit buffer
// used by leb_ctrl, leb_datapath, line_edit_buffer_top and leb_checker
// no dependencies
package leb_pkg;

  // store geometry
  localparam int LINE_DEPTH = 63;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

  // character codes
  localparam logic [7:0] NEWLINE_CODE     = 8'd10;
  localparam logic [7:0] ERASE_CODE_RESET = 8'd35;
  localparam logic [7:0] KILL_CODE_RESET  = 8'd64;

  // configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_CODE  = 1'b1;

  // input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } leb_in_t;

  // output word
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_line;
    logic       line_overflowed;
  } leb_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic read;       // read the store at the read pointer
    logic send_char;  // load the fetched character into the output register
    logic send_nl;    // load the closing newline and clear the line
  } leb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit_req;   // the presented word ends a line
    logic idx_done;   // every stored character has been sent
    logic slot_free;  // output register can take a word this cycle
  } leb_stat_t;

endpackage

// ===== sv/leb_ctrl.sv =====
// leb_ctrl: sequencer of the line edit buffer
// takes input words while idle, then steps through a line flush: store read, character send, closing newline
// depends on leb_pkg
module leb_ctrl import leb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  leb_stat_t stat,
  output leb_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SEND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && stat.emit_req) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat.idx_done) begin
          cmd.read  = 1'b1;
          state_nxt = S_SEND;
        end else if (stat.slot_free) begin
          cmd.send_nl = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SEND: begin
        if (stat.slot_free) begin
          cmd.send_char = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/leb_datapath.sv =====
// leb_datapath: line store, fill count, line flags, config and output register
// acts on leb_ctrl commands and reports status back
// depends on leb_pkg
module leb_datapath import leb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  leb_in_t               in_data,
  input  leb_cmd_t              cmd,
  output leb_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output leb_out_t              out_data
);

  logic [7:0]       erase_code_r;
  logic [7:0]       kill_code_r;
  logic [7:0]       store_mem [LINE_DEPTH];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             started_r;
  logic             ovf_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  leb_out_t         out_data_r;
  logic             is_nl;
  logic             do_edit;
  logic             do_push;

  // decode of the presented word
  assign is_nl   = (in_data.char_code == NEWLINE_CODE);
  assign do_edit = cmd.take && !in_data.end_of_stream && !is_nl;
  assign do_push = do_edit && (in_data.char_code != erase_code_r)
                   && (in_data.char_code != kill_code_r)
                   && (fill_r < CNT_W'(LINE_DEPTH));

  // status
  assign stat.emit_req  = in_data.end_of_stream ? started_r : is_nl;
  assign stat.idx_done  = (rd_idx_r == fill_r);
  assign stat.slot_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_code_r <= ERASE_CODE_RESET;
      kill_code_r  <= KILL_CODE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ERASE_CODE) begin
        erase_code_r <= cfg_wdata[7:0];
      end
      if (cfg_index == CFG_KILL_CODE) begin
        kill_code_r <= cfg_wdata[7:0];
      end
    end
  end

  // line store write and registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_mem[fill_r[ADDR_W-1:0]] <= in_data.char_code;
    end
    if (cmd.read) begin
      rd_data_r <= store_mem[rd_idx_r[ADDR_W-1:0]];
    end
  end

  // fill count, read pointer and line flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      rd_idx_r  <= '0;
      started_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (cmd.send_nl) begin
      fill_r    <= '0;
      rd_idx_r  <= '0;
      started_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (cmd.send_char) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (do_edit) begin
        started_r <= 1'b1;
        priority if (in_data.char_code == erase_code_r) begin
          if (fill_r != '0) begin
            fill_r <= fill_r - CNT_W'(1);
          end
        end else if (in_data.char_code == kill_code_r) begin
          fill_r <= '0;
        end else if (do_push) begin
          fill_r <= fill_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send_char || cmd.send_nl) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.send_char) begin
      out_data_r.out_char        <= rd_data_r;
      out_data_r.last_of_line    <= 1'b0;
      out_data_r.line_overflowed <= ovf_r;
    end else if (cmd.send_nl) begin
      out_data_r.out_char        <= NEWLINE_CODE;
      out_data_r.last_of_line    <= 1'b1;
      out_data_r.line_overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/line_edit_buffer_top.sv =====
// line_edit_buffer_top: line editor with erase and kill over a bounded line store
// joins leb_ctrl and leb_datapath
// depends on leb_pkg
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_ready  leb_in_t: char_code, end_of_stream
//   out_     output     out_valid/out_ready leb_out_t: out_char, last_of_line,
//                                           line_overflowed
//   cfg_     input      cfg_we             cfg_index, cfg_wdata (erase, kill codes)
//
// an ordinary character, erase, kill or an end of stream on an unstarted line
// leaves in_ready high, and the next word can be taken in the following cycle
// a line end is taken, then each stored character gets a registered store read, then an
// output register load, and the closing newline is loaded last; in_ready stays low from
// the line end until the closing newline is loaded
// a stalled output holds the flush at the output register
// reset is synchronous, active low; the line store itself is not cleared
module line_edit_buffer_top import leb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  leb_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output leb_out_t              out_data
);

  leb_cmd_t  cmd;
  leb_stat_t stat;

  // sequencer
  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store and output register
  leb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/leb_checker.sv =====
// leb_checker: port level checks of the line edit buffer
// bound to line_edit_buffer_top
// depends on leb_pkg
module leb_checker import leb_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input leb_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input leb_out_t out_data
);

  // no output word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // the last word of a line is the newline
  a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_line |-> out_data.out_char == NEWLINE_CODE)
    else $error("last word of a line is not a newline");

  // an accepted newline starts a flush that blocks input
  a_nl_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.end_of_stream
      && in_data.char_code == NEWLINE_CODE |=> !in_ready)
    else $error("input taken right after a newline");

  // input is held off while a line is partly sent
  a_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_line |-> !in_ready)
    else $error("input taken in the middle of a line flush");

endmodule

bind line_edit_buffer_top leb_checker u_leb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for line_edit_buffer_top, erase, kill, flush and overflow
// a shadow line editor predicts every output word; random valid/ready pacing on both sides
// depends on leb_pkg and line_edit_buffer_top
module tb_top;
  import leb_pkg::*;

  localparam int PACE_MAX      = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int RUN_LIMIT     = 3_000_000;
  localparam int RANDOM_WORDS  = 400;
  localparam int PHASE_WORDS   = 70;

  typedef struct {
    leb_in_t word;
    bit      drain_first;   // hold this word back until the last flush has drained
  } pend_word_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  leb_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  leb_out_t              out_data;

  line_edit_buffer_top u_top (.*);

  // shadow of the line editor
  logic [7:0]  erase_code_m = ERASE_CODE_RESET;
  logic [7:0]  kill_code_m  = KILL_CODE_RESET;
  logic [7:0]  line_chars [LINE_DEPTH];
  int unsigned line_fill    = 0;
  bit          line_open    = 1'b0;
  bit          line_dropped = 1'b0;

  leb_out_t    line_out_q [$];   // output words still owed by the block
  pend_word_t  char_q [$];       // input words not yet presented

  int unsigned words_queued   = 0;
  int unsigned words_sent     = 0;
  int unsigned words_seen     = 0;
  int unsigned lines_expected = 0;
  int unsigned settings_cnt   = 0;
  int unsigned err_count      = 0;
  int unsigned idle_left      = 0;
  int unsigned stall_left     = 0;
  int unsigned gap_max        = 2;
  int unsigned stall_max      = 2;
  bit          in_taken       = 1'b0;
  bit          out_taken      = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (err_count < 40) $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // emit the stored characters and the closing newline, then clear the line
  task automatic flush_line();
    leb_out_t o;
    for (int i = 0; i < line_fill; i++) begin
      o.out_char        = line_chars[ADDR_W'(i)];
      o.last_of_line    = 1'b0;
      o.line_overflowed = line_dropped;
      line_out_q.push_back(o);
    end
    o.out_char        = NEWLINE_CODE;
    o.last_of_line    = 1'b1;
    o.line_overflowed = line_dropped;
    line_out_q.push_back(o);
    line_fill    = 0;
    line_open    = 1'b0;
    line_dropped = 1'b0;
    lines_expected++;
  endtask

  // apply one accepted input word to the shadow line
  task automatic edit_char(input leb_in_t w);
    if (w.end_of_stream) begin
      if (line_open) flush_line();
    end else if (w.char_code == NEWLINE_CODE) begin
      // newline wins over matching erase or kill codes
      flush_line();
    end else begin
      line_open = 1'b1;
      if (w.char_code == erase_code_m) begin
        if (line_fill > 0) line_fill--;
      end else if (w.char_code == kill_code_m) begin
        // kill keeps the dropped flag until the line goes out
        line_fill = 0;
      end else if (line_fill < LINE_DEPTH) begin
        line_chars[ADDR_W'(line_fill)] = w.char_code;
        line_fill++;
      end else begin
        line_dropped = 1'b1;
      end
    end
  endtask

  // input driver: one word from the queue, random gap before each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) idle_left = $urandom_range(0, gap_max);
      if (idle_left != 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (char_q.size() != 0 &&
                   !(char_q[0].drain_first && line_out_q.size() != 0)) begin
        in_data  <= char_q[0].word;
        in_valid <= 1'b1;
        char_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // output ready: random stall after each word taken
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) stall_left = $urandom_range(0, stall_max);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    out_taken = 1'b0;
  end

  // monitor: check output words, then predict from accepted input words
  always @(posedge clk) begin : monitor
    leb_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        words_seen++;
        if (line_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%0d last=%0b ovf=%0b",
                                    out_data.out_char, out_data.last_of_line,
                                    out_data.line_overflowed));
        end else begin
          want = line_out_q.pop_front();
          if (out_data.out_char !== want.out_char)
            report_mismatch($sformatf("out_char got %0d want %0d",
                                      out_data.out_char, want.out_char));
          if (out_data.last_of_line !== want.last_of_line)
            report_mismatch($sformatf("last_of_line got %0b want %0b",
                                      out_data.last_of_line, want.last_of_line));
          if (out_data.line_overflowed !== want.line_overflowed)
            report_mismatch($sformatf("line_overflowed got %0b want %0b",
                                      out_data.line_overflowed, want.line_overflowed));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        words_sent++;
        edit_char(in_data);
      end
    end
  end

  task automatic push_char(input logic [7:0] ch, input bit eos, input bit drain);
    pend_word_t p;
    p.word.char_code     = ch;
    p.word.end_of_stream = eos;
    p.drain_first        = drain;
    char_q.push_back(p);
    words_queued++;
  endtask

  // one well-formed line with random content, ended by newline or end of stream
  task automatic queue_line(input int len, input bit drain, inout int cnt);
    logic [7:0] ch;
    int         r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        ch = erase_code_m;
      end else if (r < 11) begin
        ch = kill_code_m;
      end else begin
        ch = 8'($urandom_range(0, 255));
        if (ch == NEWLINE_CODE) ch = ~ch;
      end
      push_char(ch, 1'b0, drain && i == 0);
    end
    if ($urandom_range(0, 99) < 80) push_char(NEWLINE_CODE, 1'b0, drain && len == 0);
    else push_char(8'($urandom_range(0, 255)), 1'b1, drain && len == 0);
    cnt += len + 1;
  endtask

  // wait until every word is in and every expected word is out
  task automatic wait_idle();
    @(negedge clk);
    while (words_sent != words_queued || line_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write both code registers, called at a falling edge while idle
  task automatic set_codes(input logic [7:0] erase_v, input logic [7:0] kill_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ERASE_CODE;
    cfg_wdata <= erase_v;
    @(negedge clk);
    cfg_index <= CFG_KILL_CODE;
    cfg_wdata <= kill_v;
    @(negedge clk);
    cfg_we       <= 1'b0;
    erase_code_m = erase_v;
    kill_code_m  = kill_v;
    settings_cnt++;
  endtask

  // stimulus
  initial begin : stimulus
    int rand_words;
    int phase_words;
    int phase;
    int lines_in_phase;
    int r;
    int len;
    rand_words = 0;
    phase      = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset codes
    push_char(8'hFF, 1'b1, 1'b0);            // end of stream, nothing open
    push_char(NEWLINE_CODE, 1'b0, 1'b0);     // bare newline
    push_char(8'd65, 1'b0, 1'b0);
    push_char(8'd0, 1'b0, 1'b0);
    push_char(8'd255, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);
    push_char(8'd120, 1'b0, 1'b0);           // erase past empty, then flush by end of stream
    push_char(ERASE_CODE_RESET, 1'b0, 1'b0);
    push_char(ERASE_CODE_RESET, 1'b0, 1'b0);
    push_char(8'd0, 1'b1, 1'b0);
    push_char(8'd97, 1'b0, 1'b0);            // kill mid line
    push_char(8'd98, 1'b0, 1'b0);
    push_char(KILL_CODE_RESET, 1'b0, 1'b0);
    push_char(8'd99, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);
    push_char(8'd113, 1'b0, 1'b0);           // end of stream, then a new line after it
    push_char(8'hAA, 1'b1, 1'b0);
    push_char(8'd114, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);
    wait_idle();
    // newline beats an erase code of newline
    set_codes(NEWLINE_CODE, 8'd255);
    push_char(8'd122, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);
    wait_idle();
    // newline beats a kill code of newline
    set_codes(8'd0, NEWLINE_CODE);
    push_char(8'd97, 1'b0, 1'b0);
    push_char(8'd0, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);
    wait_idle();
    // equal codes erase
    set_codes(8'd77, 8'd77);
    push_char(8'd97, 1'b0, 1'b0);
    push_char(8'd98, 1'b0, 1'b0);
    push_char(8'd77, 1'b0, 1'b0);
    push_char(NEWLINE_CODE, 1'b0, 1'b0);

    // random phases, one code setting each
    while (rand_words < RANDOM_WORDS) begin
      wait_idle();
      case (phase % 6)
        0:       set_codes(ERASE_CODE_RESET, KILL_CODE_RESET);
        1:       set_codes(8'd0, 8'd255);
        2:       set_codes(8'd255, 8'd0);
        default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      gap_max        = (phase % 3 == 1) ? 0 : PACE_MAX;
      stall_max      = (phase % 4 == 2) ? 0 : PACE_MAX;
      phase_words    = 0;
      lines_in_phase = 0;
      // store overflow, then kill, then a short tail
      if (phase % 6 == 1 || phase % 6 == 2) begin
        for (int i = 0; i < LINE_DEPTH + 3; i++)
          push_char(8'($urandom_range(32, 126)), 1'b0, 1'b0);
        push_char(kill_code_m, 1'b0, 1'b0);
        push_char(8'($urandom_range(32, 126)), 1'b0, 1'b0);
        push_char(8'($urandom_range(32, 126)), 1'b0, 1'b0);
        push_char(NEWLINE_CODE, 1'b0, 1'b0);
        phase_words += LINE_DEPTH + 7;
      end
      while (phase_words < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // noise word
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
          phase_words++;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80) len = $urandom_range(0, 12);
          else if (r < 95) len = $urandom_range(13, 45);
          else len = $urandom_range(58, 75);
          queue_line(len, lines_in_phase == 1 || $urandom_range(0, 29) == 0, phase_words);
          lines_in_phase++;
        end
      end
      rand_words += phase_words;
      phase++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("sent %0d input words under %0d code settings", words_sent, settings_cnt + 1);
    $display("checked %0d output words over %0d lines, %0d mismatches",
             words_seen, lines_expected, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d output words outstanding", line_out_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/leb_pkg.sv
sv/leb_ctrl.sv
sv/leb_datapath.sv
sv/line_edit_buffer_top.sv
sv/leb_checker.sv
tb/tb_top.sv
